// ===== design/bbx_pkg.sv =====
// Shared types and constants of the forbidden-byte XOR escaper.
package bbx_pkg;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_SET_0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_SET_1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_SET_2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_SET_3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 3'd4;

  localparam int BASE_W    = 31;
  localparam int ADDR_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int MAP_W     = 256;

  // Key search range.
  localparam logic [BYTE_W-1:0] KEY_FIRST = 8'd1;
  localparam logic [BYTE_W-1:0] KEY_LAST  = 8'd254;
  localparam logic [BYTE_W-1:0] KEY_NONE  = 8'd0;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = 1;
  localparam int QUEUE_CNT_W = 2;

  typedef struct packed {
    logic [BYTE_W-1:0] content_byte;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              escaped;
    logic [ADDR_W-1:0] byte_address;
    logic [BYTE_W-1:0] key;
    logic              key_ok;
    logic              is_last;
    logic              none_found;
    logic              too_long;
  } out_item_t;

  // Item after classification in the front.
  typedef struct packed {
    logic [BYTE_W-1:0] content_byte;
    logic              last;
    logic              bad;
  } cls_item_t;

  // Result of the key search.
  typedef struct packed {
    logic              done;
    logic              ok;
    logic [BYTE_W-1:0] key;
  } ks_res_t;

endpackage

// ===== design/bbx_front.sv =====
// Front part: accepts items, classifies them against the forbidden set and queues them.
module bbx_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bbx_pkg::in_item_t            in_data,
  input  logic [bbx_pkg::MAP_W-1:0]    bad_map,
  input  logic                         pop,
  output logic                         head_valid,
  output bbx_pkg::cls_item_t           head
);

  bbx_pkg::cls_item_t                   mem_r [bbx_pkg::QUEUE_DEPTH];
  logic [bbx_pkg::QUEUE_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [bbx_pkg::QUEUE_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [bbx_pkg::QUEUE_CNT_W-1:0]      count_r, count_nxt;
  logic                                 push;
  bbx_pkg::cls_item_t                   cls;

  // Stall only on a full queue, so it never looks at valid.
  assign in_stall   = (count_r == bbx_pkg::QUEUE_CNT_W'(bbx_pkg::QUEUE_DEPTH));
  assign push       = in_valid && !in_stall;
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  // Classify the incoming byte with the bitmap as it stands now.
  always_comb begin
    cls.content_byte = in_data.content_byte;
    cls.last         = in_data.last;
    cls.bad          = bad_map[in_data.content_byte];
  end

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== design/bbx_key_search.sv =====
// Key search unit: tests one candidate XOR key per cycle against the forbidden set.
module bbx_key_search (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [bbx_pkg::MAP_W-1:0]    bad_map,
  output bbx_pkg::ks_res_t             res
);

  logic                          busy_r, busy_nxt;
  logic [bbx_pkg::BYTE_W-1:0]    key_r, key_nxt;
  logic [bbx_pkg::MAP_W-1:0]     moved;
  logic                          conflict;

  // Permute the bitmap so that bit b holds the flag of byte b XOR k.
  // Eight butterfly layers, one per key bit.
  function automatic logic [bbx_pkg::MAP_W-1:0] xor_permute(
    input logic [bbx_pkg::MAP_W-1:0] map,
    input logic [bbx_pkg::BYTE_W-1:0] k
  );
    logic [bbx_pkg::MAP_W-1:0] cur;
    logic [bbx_pkg::MAP_W-1:0] nxt;
    cur = map;
    for (int j = 0; j < bbx_pkg::BYTE_W; j++) begin
      for (int b = 0; b < bbx_pkg::MAP_W; b++) begin
        nxt[b] = k[j] ? cur[b ^ (1 << j)] : cur[b];
      end
      cur = nxt;
    end
    return cur;
  endfunction

  // A key fails when some forbidden byte maps onto another forbidden byte.
  assign moved    = xor_permute(bad_map, key_r);
  assign conflict = |(bad_map & moved);

  always_comb begin
    res.done = busy_r && (!conflict || (key_r == bbx_pkg::KEY_LAST));
    res.ok   = !conflict;
    res.key  = conflict ? bbx_pkg::KEY_NONE : key_r;
  end

  // Walk the candidates from the smallest upward.
  always_comb begin
    busy_nxt = busy_r;
    key_nxt  = key_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        key_nxt  = bbx_pkg::KEY_FIRST;
      end
    end else if (res.done) begin
      busy_nxt = 1'b0;
    end else begin
      key_nxt = key_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      key_r  <= bbx_pkg::KEY_FIRST;
    end else begin
      busy_r <= busy_nxt;
      key_r  <= key_nxt;
    end
  end

endmodule

// ===== design/bbx_back.sv =====
// Back part: obtains the run key, escapes queued items and builds the result items.
module bbx_back #(
  parameter int POSITION_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  bbx_pkg::cls_item_t            head,
  output logic                          pop,
  output logic                          ks_start,
  input  bbx_pkg::ks_res_t              ks_res,
  input  logic [bbx_pkg::BASE_W-1:0]    base_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bbx_pkg::out_item_t            out_data
);

  localparam int SUM_W = bbx_pkg::ADDR_W + 1;

  typedef enum logic [2:0] {
    BK_NEED   = 3'b001,
    BK_SEARCH = 3'b010,
    BK_RUN    = 3'b100
  } back_state_t;

  back_state_t                   state_r, state_nxt;
  logic [bbx_pkg::BYTE_W-1:0]    key_r, key_nxt;
  logic                          ok_r, ok_nxt;
  logic [POSITION_BITS-1:0]      pos_r, pos_nxt;
  logic                          any_bad_r, any_bad_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          max_used_r, max_used_nxt;
  logic                          out_valid_r, out_valid_nxt;
  bbx_pkg::out_item_t            out_data_r, out_data_nxt;
  logic                          out_free;
  logic                          esc;
  logic                          any_now;
  logic                          ovf_now;
  logic [SUM_W-1:0]              addr_sum;

  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = (state_r == BK_RUN) && head_valid && out_free;
  assign ks_start  = (state_r == BK_NEED) && head_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Per-item escape, flags and address.
  always_comb begin
    esc      = head.bad && ok_r;
    any_now  = any_bad_r || head.bad;
    ovf_now  = ovf_r || max_used_r;
    addr_sum = {2'b00, base_address} + {{(SUM_W - POSITION_BITS){1'b0}}, pos_r};

    out_data_nxt.out_byte     = esc ? (head.content_byte ^ key_r) : head.content_byte;
    out_data_nxt.escaped      = esc;
    out_data_nxt.byte_address = addr_sum[bbx_pkg::ADDR_W-1:0];
    out_data_nxt.key          = key_r;
    out_data_nxt.key_ok       = ok_r;
    out_data_nxt.is_last      = head.last;
    out_data_nxt.none_found   = head.last && !any_now;
    out_data_nxt.too_long     = ovf_now;
  end

  // Run control: search the key on the first item, then stream.
  always_comb begin
    state_nxt    = state_r;
    key_nxt      = key_r;
    ok_nxt       = ok_r;
    pos_nxt      = pos_r;
    any_bad_nxt  = any_bad_r;
    ovf_nxt      = ovf_r;
    max_used_nxt = max_used_r;
    case (state_r)
      BK_NEED: begin
        if (head_valid) begin
          state_nxt = BK_SEARCH;
        end
      end
      BK_SEARCH: begin
        if (ks_res.done) begin
          key_nxt   = ks_res.key;
          ok_nxt    = ks_res.ok;
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (pop) begin
          if (head.last) begin
            state_nxt    = BK_NEED;
            pos_nxt      = '0;
            any_bad_nxt  = 1'b0;
            ovf_nxt      = 1'b0;
            max_used_nxt = 1'b0;
          end else begin
            any_bad_nxt = any_now;
            ovf_nxt     = ovf_now;
            if (&pos_r) begin
              max_used_nxt = 1'b1;
            end else begin
              pos_nxt = pos_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = BK_NEED;
      end
    endcase
  end

  // Output register holds a result until it is taken.
  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_NEED;
      key_r       <= bbx_pkg::KEY_NONE;
      ok_r        <= 1'b0;
      pos_r       <= '0;
      any_bad_r   <= 1'b0;
      ovf_r       <= 1'b0;
      max_used_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      key_r       <= key_nxt;
      ok_r        <= ok_nxt;
      pos_r       <= pos_nxt;
      any_bad_r   <= any_bad_nxt;
      ovf_r       <= ovf_nxt;
      max_used_r  <= max_used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ===== design/bad_byte_xor_escaper.sv =====
// Top level of the forbidden-byte XOR escaper: configuration registers and part wiring.
//
//   Channel   Direction  Handshake           Payload
//   in_       input      in_valid/in_stall   in_item_t  (content_byte, last)
//   out_      output     out_valid/out_stall out_item_t (out_byte .. too_long)
//   cfg_      input      cfg_we              cfg_index, cfg_data
//
// Once a run has its key, items pass to the output register one per cycle unless stalled.
// The first item of each run waits for the key search unit, which tests one key per cycle
// from key 1 upward until one fits or key 254 fails, then passes the queue and output register.
// Sync reset (rst_n low) clears all but data stores and starts a new run; no clearing pass.
// in_stall rises only when the two-entry queue is full; out_stall holds the output register.
module bad_byte_xor_escaper #(
  parameter int POSITION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bbx_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bbx_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [bbx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bbx_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [bbx_pkg::CFG_DATA_W-1:0] bad_set_0_r, bad_set_1_r, bad_set_2_r, bad_set_3_r;
  logic [bbx_pkg::BASE_W-1:0]     base_r;
  logic [bbx_pkg::MAP_W-1:0]      bad_map;
  logic                           head_valid;
  bbx_pkg::cls_item_t             head;
  logic                           pop;
  logic                           ks_start;
  bbx_pkg::ks_res_t               ks_res;

  assign bad_map = {bad_set_3_r, bad_set_2_r, bad_set_1_r, bad_set_0_r};

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bad_set_0_r <= '0;
      bad_set_1_r <= '0;
      bad_set_2_r <= '0;
      bad_set_3_r <= '0;
      base_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bbx_pkg::CFG_BAD_SET_0:    bad_set_0_r <= cfg_data;
        bbx_pkg::CFG_BAD_SET_1:    bad_set_1_r <= cfg_data;
        bbx_pkg::CFG_BAD_SET_2:    bad_set_2_r <= cfg_data;
        bbx_pkg::CFG_BAD_SET_3:    bad_set_3_r <= cfg_data;
        bbx_pkg::CFG_BASE_ADDRESS: base_r      <= cfg_data[bbx_pkg::BASE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept, classify and queue.
  bbx_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .bad_map    (bad_map),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Key search shared by every run.
  bbx_key_search u_key_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ks_start),
    .bad_map (bad_map),
    .res     (ks_res)
  );

  // Back: escape and report.
  bbx_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .ks_start     (ks_start),
    .ks_res       (ks_res),
    .base_address (base_r),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data)
  );

  // An escaped byte needs a good key, and a failed search reports key zero.
  a_esc_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.key_ok || (!out_data.escaped && out_data.key == '0)))
    else $error("escaped byte or nonzero key without a good key");

  // The empty-run flag appears only on the last result of a run.
  a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.none_found) |-> out_data.is_last)
    else $error("none_found set on a result that is not last");

  // A key search is started by a single-cycle request.
  a_start_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    ks_start |=> !ks_start)
    else $error("key search request held for more than one cycle");

  // The queue is never popped while the search request is out.
  a_no_pop_search: assert property (@(posedge clk) disable iff (!rst_n)
    ks_start |-> !pop)
    else $error("item taken before the run key is known");

endmodule

// ===== sim/testbench.sv =====
// Testbench for the forbidden-byte XOR escaper: stimulus, escaping predictor and result checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POS_BITS = 16;
  localparam logic [31:0] POS_MAX = 32'((64'd1 << POS_BITS) - 1);
  localparam int RANDOM_ITEMS = 750;
  localparam int HOLDOFF_CYCLES = 300;
  // Worst run: every item opening a run (each with a full key search) under heavy stalls,
  // plus the receiver hold-off and the register writes, taken several times over.
  localparam int LIMIT_CYCLES = 3_000_000;

  typedef enum logic [2:0] {
    KEY_UNSEARCHED = 3'b001,
    KEY_FOUND      = 3'b010,
    KEY_FAILED     = 3'b100
  } key_search_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bbx_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bbx_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [bbx_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bbx_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Idle rates and the receiver hold-off, set by the stimulus.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_start = 1'b0;
  int hold_left = 0;

  // Shadow of the configuration and of the per-run state of the block.
  logic [bbx_pkg::MAP_W-1:0] bad_map = '0;
  logic [bbx_pkg::BASE_W-1:0] base_addr = '0;
  key_search_t key_state = KEY_UNSEARCHED;
  logic [bbx_pkg::BYTE_W-1:0] run_key = bbx_pkg::KEY_NONE;
  logic [31:0] run_pos = '0;
  logic run_bad_seen = 1'b0;
  logic run_overflow = 1'b0;
  logic run_top_used = 1'b0;

  bbx_pkg::in_item_t bytes_to_send[$];
  bbx_pkg::out_item_t due_results[$];
  int items_queued = 0;
  int items_taken = 0;
  int results_seen = 0;
  int error_count = 0;
  int run_left = 0;
  int cycle_count = 0;
  int runs_closed = 0;
  int bytes_escaped = 0;
  int failed_key_results = 0;
  int saturated_results = 0;

  bad_byte_xor_escaper #(.POSITION_BITS(POS_BITS)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Predict the result of one content byte and advance the run state.
  function automatic bbx_pkg::out_item_t escape_byte(bbx_pkg::in_item_t item);
    bbx_pkg::out_item_t res;
    logic bad;
    logic ok;
    logic good;
    // The first byte of a run picks the smallest key that maps no forbidden byte onto another.
    if (key_state == KEY_UNSEARCHED) begin
      key_state = KEY_FAILED;
      run_key = bbx_pkg::KEY_NONE;
      for (int k = int'(bbx_pkg::KEY_FIRST); k <= int'(bbx_pkg::KEY_LAST); k++) begin
        good = 1'b1;
        for (int b = 0; b < bbx_pkg::MAP_W; b++)
          if (bad_map[b] && bad_map[b ^ k]) good = 1'b0;
        if (good && key_state != KEY_FOUND) begin
          key_state = KEY_FOUND;
          run_key = k[bbx_pkg::BYTE_W-1:0];
        end
      end
    end
    ok = (key_state == KEY_FOUND);
    bad = bad_map[item.content_byte];
    if (bad) run_bad_seen = 1'b1;
    // Once the top position has been handed out, the rest of the run is flagged.
    if (run_top_used) run_overflow = 1'b1;
    res.byte_address = bbx_pkg::ADDR_W'(base_addr) + run_pos;
    if (run_pos < POS_MAX) run_pos = run_pos + 32'd1;
    else run_top_used = 1'b1;
    res.out_byte = (bad && ok) ? item.content_byte ^ run_key : item.content_byte;
    res.escaped = bad && ok;
    res.key = ok ? run_key : bbx_pkg::KEY_NONE;
    res.key_ok = ok;
    res.is_last = item.last;
    res.none_found = item.last && !run_bad_seen;
    res.too_long = run_overflow;
    bytes_escaped += int'(res.escaped);
    failed_key_results += int'(!ok);
    saturated_results += int'(run_overflow);
    if (item.last) begin
      key_state = KEY_UNSEARCHED;
      run_pos = '0;
      run_bad_seen = 1'b0;
      run_overflow = 1'b0;
      run_top_used = 1'b0;
      runs_closed++;
    end
    return res;
  endfunction

  task automatic report_error(string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_error($sformatf("result %0d: %s is %0h, expected %0h", results_seen, name, got, want));
  endtask

  // Sender: offers queued items, holding each until the block takes it.
  always @(posedge clk) begin : drive_items
    logic offer_free;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer_free = !in_valid;
      if (in_valid && !in_stall) begin
        due_results.push_back(escape_byte(in_data));
        items_taken++;
        offer_free = 1'b1;
      end
      if (offer_free) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= bytes_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin : check_results
    bbx_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = due_results.pop_front();
          check_field("out_byte", 32'(out_data.out_byte), 32'(want.out_byte));
          check_field("escaped", 32'(out_data.escaped), 32'(want.escaped));
          check_field("byte_address", out_data.byte_address, want.byte_address);
          check_field("key", 32'(out_data.key), 32'(want.key));
          check_field("key_ok", 32'(out_data.key_ok), 32'(want.key_ok));
          check_field("is_last", 32'(out_data.is_last), 32'(want.is_last));
          check_field("none_found", 32'(out_data.none_found), 32'(want.none_found));
          check_field("too_long", 32'(out_data.too_long), 32'(want.too_long));
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_start) begin
      hold_left <= HOLDOFF_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_results.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // One register write; the shadow follows once the block has taken it.
  task automatic write_reg(logic [bbx_pkg::CFG_IDX_W-1:0] idx,
                           logic [bbx_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bbx_pkg::CFG_BAD_SET_0: bad_map[63:0] = value;
      bbx_pkg::CFG_BAD_SET_1: bad_map[127:64] = value;
      bbx_pkg::CFG_BAD_SET_2: bad_map[191:128] = value;
      bbx_pkg::CFG_BAD_SET_3: bad_map[255:192] = value;
      bbx_pkg::CFG_BASE_ADDRESS: base_addr = value[bbx_pkg::BASE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_map(logic [bbx_pkg::MAP_W-1:0] map,
                          logic [bbx_pkg::CFG_DATA_W-1:0] base);
    write_reg(bbx_pkg::CFG_BAD_SET_0, map[63:0]);
    write_reg(bbx_pkg::CFG_BAD_SET_1, map[127:64]);
    write_reg(bbx_pkg::CFG_BAD_SET_2, map[191:128]);
    write_reg(bbx_pkg::CFG_BAD_SET_3, map[255:192]);
    write_reg(bbx_pkg::CFG_BASE_ADDRESS, base);
  endtask

  task automatic queue_item(logic [bbx_pkg::BYTE_W-1:0] value, logic last);
    bytes_to_send.push_back(bbx_pkg::in_item_t'{content_byte: value, last: last});
    items_queued++;
  endtask

  // Block until every queued item was taken and every result has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (items_taken != items_queued || due_results.size() != 0);
  endtask

  // Random runs, mostly short; about half the bytes are drawn from the forbidden set.
  task automatic queue_random(int count);
    logic [bbx_pkg::BYTE_W-1:0] value;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0)
        run_left = ($urandom_range(3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      value = 8'($urandom);
      if (bad_map != '0 && $urandom_range(1) == 1)
        while (!bad_map[value]) value = 8'($urandom);
      run_left--;
      queue_item(value, run_left == 0);
    end
  endtask

  // Forbidden sets from empty to full, mostly sparse enough for a key to exist.
  function automatic logic [bbx_pkg::MAP_W-1:0] random_map();
    logic [bbx_pkg::MAP_W-1:0] map;
    logic [bbx_pkg::MAP_W-1:0] r1;
    logic [bbx_pkg::MAP_W-1:0] r2;
    for (int w = 0; w < bbx_pkg::MAP_W / 32; w++) begin
      r1[w*32 +: 32] = $urandom;
      r2[w*32 +: 32] = $urandom;
    end
    case ($urandom_range(9))
      0: map = '0;
      1: map = '1;
      7: map = r1 & r2;
      8: map = r1;
      9: map = r1 | r2;
      default: begin
        map = '0;
        repeat ($urandom_range(1, 24)) map[8'($urandom_range(bbx_pkg::MAP_W - 1))] = 1'b1;
      end
    endcase
    return map;
  endfunction

  function automatic logic [bbx_pkg::CFG_DATA_W-1:0] random_base();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct <= 24;
    recv_idle_pct <= 66;

    // Reset configuration: empty forbidden set, so key 1 and nothing escaped.
    queue_item(8'h00, 1'b0);
    queue_item(8'hFF, 1'b0);
    queue_item(8'h5A, 1'b1);
    wait_drained();

    // Bytes 0x00, 0x01 and 0xFF forbidden gives key 2; base at its maximum.
    load_map(256'h1 | 256'h2 | (256'h1 << 255), '1);
    queue_item(8'h00, 1'b1);
    queue_item(8'hFF, 1'b0);
    queue_item(8'h01, 1'b0);
    queue_item(8'h80, 1'b1);
    wait_drained();

    // Writes past the register list must leave everything alone.
    for (int i = int'(bbx_pkg::CFG_BASE_ADDRESS) + 1; i < 2 ** bbx_pkg::CFG_IDX_W; i++)
      write_reg(bbx_pkg::CFG_IDX_W'(i), '1);
    queue_item(8'h00, 1'b1);
    wait_drained();

    // Everything forbidden: the key search fails and bytes pass unchanged.
    load_map('1, '0);
    queue_item(8'h00, 1'b0);
    queue_item(8'hFF, 1'b0);
    queue_item(8'h33, 1'b1);
    wait_drained();

    // Lower half forbidden: only keys with the top bit set qualify.
    load_map({128'h0, {128{1'b1}}}, 64'h1234);
    queue_item(8'h7F, 1'b0);
    queue_item(8'h80, 1'b1);
    wait_drained();

    // Reconfigure in the middle of a run: the key stays, the forbidden test follows the map.
    load_map(256'h1 << 8'h10, 64'h100);
    queue_item(8'h10, 1'b0);
    wait_drained();
    load_map('1, 64'h200);
    queue_item(8'h10, 1'b0);
    queue_item(8'hC3, 1'b1);
    queue_item(8'h00, 1'b1);
    wait_drained();

    // Random runs in three idling regimes, the configuration changed between segments.
    for (int phase = 0; phase < 3; phase++) begin
      @(posedge clk);
      send_idle_pct <= (phase == 0) ? 24 : (phase == 1) ? 66 : 0;
      recv_idle_pct <= (phase == 0) ? 66 : (phase == 1) ? 24 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        wait_drained();
        load_map(random_map(), random_base());
        if ($urandom_range(3) == 0)
          write_reg(bbx_pkg::CFG_IDX_W'(int'(bbx_pkg::CFG_BASE_ADDRESS) + 1 +
                                        $urandom_range(2)),
                    {$urandom, $urandom});
        queue_random(RANDOM_ITEMS / 12);
        if (phase == 0 && seg == 1) begin
          @(posedge clk);
          hold_start <= 1'b1;
          @(posedge clk);
          hold_start <= 1'b0;
        end
      end
    end

    wait_drained();
    repeat (16) @(posedge clk);
    $display("summary: %0d items, %0d results checked, %0d runs closed, %0d bytes escaped",
             items_taken, results_seen, runs_closed, bytes_escaped);
    $display("summary: %0d results without a key, %0d results past the position limit",
             failed_key_results, saturated_results);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bbx_pkg.sv
design/bbx_front.sv
design/bbx_key_search.sv
design/bbx_back.sv
design/bad_byte_xor_escaper.sv
sim/testbench.sv
